FILE: sv/xkp_pkg.sv
package xkp_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    OP_MAKE  = 2'd0,
    OP_BREAK = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  // port offsets from 0x60
  localparam logic [1:0] PORT_DATA   = 2'd0;
  localparam logic [1:0] PORT_B      = 2'd1;
  localparam logic [1:0] PORT_SWITCH = 2'd2;

  // configuration register indexes
  localparam logic REG_DIP_LOW  = 1'b0;
  localparam logic REG_DIP_HIGH = 1'b1;

  localparam logic [7:0] BREAK_BIT   = 8'h80;
  localparam logic [7:0] UNUSED_PORT = 8'hFF;
  localparam int         PB_IRQ_CLR  = 7;
  localparam int         PB_DIP_SEL  = 2;
  localparam int         PB_GATE     = 0;
  localparam int         PB_SPK_EN   = 1;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_data;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

FILE: sv/xkp_fifo.sv
module xkp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  xkp_pkg::fifo_ctl_t ctl,
  output xkp_pkg::fifo_sts_t sts,
  output logic [7:0]        head_data
);

  logic [7:0]                 scan_fifo_r [xkp_pkg::FIFO_DEPTH];
  logic [xkp_pkg::FIFO_AW-1:0] head_r, head_nxt;
  logic [xkp_pkg::FIFO_AW-1:0] tail_r, tail_nxt;
  logic [xkp_pkg::FIFO_AW-1:0] tail_inc, head_inc;

  localparam logic [xkp_pkg::FIFO_AW-1:0] LAST =
    xkp_pkg::FIFO_AW'(xkp_pkg::FIFO_DEPTH - 1);

  always_comb begin
    tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  end

  // ring keeps one slot free: full when the tail would run into the head
  assign sts.empty = (head_r == tail_r);
  assign sts.full  = (tail_inc == head_r);
  assign head_data = scan_fifo_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.push && !sts.full) begin
      tail_nxt = tail_inc;
    end
    if (ctl.pop && !sts.empty) begin
      head_nxt = head_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !sts.full) begin
      scan_fifo_r[tail_r] <= ctl.push_data;
    end
  end

endmodule

FILE: sv/xt_keyboard_ppi_port.sv
// An accepted word passes from the input register to the result register.
// Throughput: one word per cycle unless out_ready stalls; the keyboard state
// (latch, port B, IRQ, ring pointers) updates when the result register loads.
// Reset (rst_n, synchronous, active low): pipeline empty, latch, port B, IRQ,
// DIP registers and ring pointers cleared; ring storage is not cleared.
module xt_keyboard_ppi_port (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [6:0]                 in_scancode,
  input  logic [1:0]                 in_port_offset,
  input  logic [7:0]                 in_write_data,
  input  logic                       in_pit_ch2_out,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_read_data,
  output logic                       out_irq_line,
  output logic                       out_speaker_gate,
  output logic                       out_speaker_enable,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [xkp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [xkp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [xkp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  // configuration
  logic [3:0] dip_low_r, dip_high_r;
  logic       cfg_wr;
  logic       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_low_r  <= '0;
      dip_high_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == xkp_pkg::REG_DIP_LOW) begin
        dip_low_r <= cfg_pwdata[3:0];
      end else begin
        dip_high_r <= cfg_pwdata[3:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx == xkp_pkg::REG_DIP_LOW) begin
      cfg_prdata[3:0] = dip_low_r;
    end else begin
      cfg_prdata[3:0] = dip_high_r;
    end
  end

  // input register
  logic       s1_valid_r;
  logic [1:0] s1_opcode_r;
  logic [6:0] s1_scancode_r;
  logic [1:0] s1_offset_r;
  logic [7:0] s1_wdata_r;
  logic       s1_pit_r;
  logic       s1_go;

  assign s1_go    = s1_valid_r && (out_ready || !out_valid);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode_r   <= in_opcode;
      s1_scancode_r <= in_scancode;
      s1_offset_r   <= in_port_offset;
      s1_wdata_r    <= in_write_data;
      s1_pit_r      <= in_pit_ch2_out;
    end
  end

  // keyboard / PPI state
  logic [7:0]         latch_r, latch_nxt;
  logic [7:0]         port_b_r, port_b_nxt;
  logic               irq_r, irq_nxt;
  logic [7:0]         rd;
  logic [7:0]         key_code;
  logic [3:0]         dip_sel;
  xkp_pkg::op_t       op;
  xkp_pkg::fifo_ctl_t fifo_ctl;
  xkp_pkg::fifo_sts_t fifo_sts;
  logic [7:0]         fifo_head_data;

  xkp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .sts       (fifo_sts),
    .head_data (fifo_head_data)
  );

  always_comb begin
    op        = xkp_pkg::op_t'(s1_opcode_r);
    key_code  = {1'b0, s1_scancode_r};
    if (op == xkp_pkg::OP_BREAK) begin
      key_code = key_code | xkp_pkg::BREAK_BIT;
    end
    dip_sel   = port_b_r[xkp_pkg::PB_DIP_SEL] ? dip_high_r : dip_low_r;
    latch_nxt = latch_r;
    port_b_nxt = port_b_r;
    irq_nxt   = irq_r;
    rd        = '0;
    fifo_ctl  = '{push: 1'b0, pop: 1'b0, push_data: key_code};

    case (op)
      xkp_pkg::OP_MAKE, xkp_pkg::OP_BREAK: begin
        if (!irq_r) begin
          latch_nxt = key_code;
          irq_nxt   = 1'b1;
        end else begin
          fifo_ctl.push = s1_go && !fifo_sts.full;
        end
      end
      xkp_pkg::OP_READ: begin
        case (s1_offset_r)
          xkp_pkg::PORT_DATA:   rd = latch_r;
          xkp_pkg::PORT_B:      rd = port_b_r;
          xkp_pkg::PORT_SWITCH: rd = {2'b00, s1_pit_r, 1'b0, dip_sel};
          default:              rd = xkp_pkg::UNUSED_PORT;
        endcase
      end
      xkp_pkg::OP_WRITE: begin
        if (s1_offset_r == xkp_pkg::PORT_B) begin
          port_b_nxt = s1_wdata_r;
          if (s1_wdata_r[xkp_pkg::PB_IRQ_CLR] && !port_b_r[xkp_pkg::PB_IRQ_CLR]) begin
            irq_nxt = 1'b0;
          end
          // bit 7 falling acknowledges: next queued code goes to the latch
          if (!s1_wdata_r[xkp_pkg::PB_IRQ_CLR] && port_b_r[xkp_pkg::PB_IRQ_CLR] &&
              !fifo_sts.empty) begin
            latch_nxt    = fifo_head_data;
            irq_nxt      = 1'b1;
            fifo_ctl.pop = s1_go;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r  <= '0;
      port_b_r <= '0;
      irq_r    <= 1'b0;
    end else if (s1_go) begin
      latch_r  <= latch_nxt;
      port_b_r <= port_b_nxt;
      irq_r    <= irq_nxt;
    end
  end

  // result register
  logic       out_valid_r;
  logic [7:0] out_rd_r;
  logic       out_irq_r, out_gate_r, out_spk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_rd_r   <= rd;
      out_irq_r  <= irq_nxt;
      out_gate_r <= port_b_nxt[xkp_pkg::PB_GATE];
      out_spk_r  <= port_b_nxt[xkp_pkg::PB_SPK_EN];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_rd_r;
  assign out_irq_line       = out_irq_r;
  assign out_speaker_gate   = out_gate_r;
  assign out_speaker_enable = out_spk_r;

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_ctl.push && fifo_ctl.pop))
    else $error("ring push and pop in the same cycle");

  a_push_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ctl.push |-> irq_r && !fifo_sts.full)
    else $error("key queued while latch free or ring full");

  a_key_to_latch: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !irq_r && (op == xkp_pkg::OP_MAKE || op == xkp_pkg::OP_BREAK)
    |=> irq_r && latch_r == $past(key_code))
    else $error("key with no IRQ pending did not reach the latch");

  a_ack_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && op == xkp_pkg::OP_WRITE && s1_offset_r == xkp_pkg::PORT_B &&
    s1_wdata_r[xkp_pkg::PB_IRQ_CLR] && !port_b_r[xkp_pkg::PB_IRQ_CLR]
    |=> !irq_r)
    else $error("port B bit 7 rising did not clear IRQ");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s1_go) |-> out_irq_r == irq_r && out_gate_r == port_b_r[xkp_pkg::PB_GATE])
    else $error("result word disagrees with updated state");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import xkp_pkg::*;

  localparam logic [1:0] PORT_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         HOLD_CYCLES    = 60;
  localparam int         RAND_PER_PHASE = 95;
  localparam int         N_DIR          = 23;

  typedef struct packed {
    op_t        op;
    logic [6:0] sc;
    logic [1:0] off;
    logic [7:0] wd;
    logic       pit;
  } ppi_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
    logic       gate;
    logic       en;
  } ppi_res_t;

  typedef struct packed {
    ppi_word_t  w;
    logic [4:0] rep;
    logic       chk;
    ppi_res_t   res;
  } dir_row_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [1:0]          in_opcode      = '0;
  logic [6:0]          in_scancode    = '0;
  logic [1:0]          in_port_offset = '0;
  logic [7:0]          in_write_data  = '0;
  logic                in_pit_ch2_out = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [7:0]          out_read_data;
  logic                out_irq_line;
  logic                out_speaker_gate;
  logic                out_speaker_enable;
  logic                cfg_psel       = 1'b0;
  logic                cfg_penable    = 1'b0;
  logic                cfg_pwrite     = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr      = '0;
  logic [CFG_DW-1:0]   cfg_pwdata     = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // typed-in expectation travels with the word it belongs to
  logic                cur_chk        = 1'b0;
  ppi_res_t            cur_typed      = '0;

  logic                hold_req       = 1'b0;
  logic                hold_done      = 1'b0;
  logic                no_stall       = 1'b0;
  int                  low_left       = 0;
  int                  rdy_roll;
  int                  idle_cycles    = 0;
  int                  n_fail         = 0;
  int                  n_cfg_fail     = 0;

  // shadow of the keyboard port state
  logic [7:0]          ring_m [FIFO_DEPTH];
  int                  head_m         = 0;
  int                  tail_m         = 0;
  logic [7:0]          latch_m        = '0;
  logic [7:0]          pb_m           = '0;
  logic                irq_m          = 1'b0;
  logic [3:0]          dip_lo_m       = '0;
  logic [3:0]          dip_hi_m       = '0;

  ppi_res_t            ppi_res_q [$];

  dir_row_t dir_tab [N_DIR] = '{
    '{'{OP_READ,  7'h00, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  7'h7F, PORT_SWITCH, 8'h00, 1'b1}, 5'd1,  1'b1, '{8'h20, 1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  7'h00, PORT_UNUSED, 8'h00, 1'b0}, 5'd1,  1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h03, 1'b0}, 5'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{'{OP_MAKE,  7'h7F, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{'{OP_READ,  7'h00, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b1, '{8'h7F, 1'b1, 1'b1, 1'b1}},
    '{'{OP_BREAK, 7'h00, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_BREAK, 7'h7F, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h80, 1'b0}, 5'd1,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h00, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_READ,  7'h00, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h84, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_READ,  7'h00, PORT_SWITCH, 8'h00, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h04, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h80, 1'b0}, 5'd1,  1'b0, '0},
    // falling bit 7 with nothing queued, then rising with irq already clear
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h00, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h80, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_DATA,   8'hFF, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_SWITCH, 8'h55, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_WRITE, 7'h00, PORT_B,      8'h7F, 1'b0}, 5'd1,  1'b0, '0},
    '{'{OP_MAKE,  7'h01, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b0, '0},
    // overfills the ring: the last keys are dropped
    '{'{OP_MAKE,  7'h10, PORT_DATA,   8'h00, 1'b0}, 5'd17, 1'b0, '0},
    '{'{OP_READ,  7'h00, PORT_DATA,   8'h00, 1'b0}, 5'd1,  1'b0, '0}
  };

  xt_keyboard_ppi_port u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_scancode       (in_scancode),
    .in_port_offset    (in_port_offset),
    .in_write_data     (in_write_data),
    .in_pit_ch2_out    (in_pit_ch2_out),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_irq_line      (out_irq_line),
    .out_speaker_gate  (out_speaker_gate),
    .out_speaker_enable(out_speaker_enable),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic ppi_res_t kbd_ppi_step(input ppi_word_t w);
    ppi_res_t   r;
    logic [7:0] code;
    logic [7:0] old;
    r = '0;
    case (w.op)
      OP_MAKE, OP_BREAK: begin
        code = {1'b0, w.sc};
        if (w.op == OP_BREAK) code = code | BREAK_BIT;
        if (!irq_m) begin
          latch_m = code;
          irq_m   = 1'b1;
        end else if ((tail_m + 1) % FIFO_DEPTH != head_m) begin
          ring_m[FIFO_AW'(tail_m)] = code;
          tail_m                   = (tail_m + 1) % FIFO_DEPTH;
        end
      end
      OP_READ: begin
        case (w.off)
          PORT_DATA:   r.rd = latch_m;
          PORT_B:      r.rd = pb_m;
          PORT_SWITCH: r.rd = {2'b00, w.pit, 1'b0, pb_m[PB_DIP_SEL] ? dip_hi_m : dip_lo_m};
          default:     r.rd = UNUSED_PORT;
        endcase
      end
      default: begin
        if (w.off == PORT_B) begin
          old  = pb_m;
          pb_m = w.wd;
          if (pb_m[PB_IRQ_CLR] && !old[PB_IRQ_CLR]) irq_m = 1'b0;
          if (!pb_m[PB_IRQ_CLR] && old[PB_IRQ_CLR] && head_m != tail_m) begin
            latch_m = ring_m[FIFO_AW'(head_m)];
            head_m  = (head_m + 1) % FIFO_DEPTH;
            irq_m   = 1'b1;
          end
        end
      end
    endcase
    r.irq  = irq_m;
    r.gate = pb_m[PB_GATE];
    r.en   = pb_m[PB_SPK_EN];
    return r;
  endfunction

  // mostly acks that flip port B bit 7 and key events, some reads and noise
  function automatic ppi_word_t gen_word();
    ppi_word_t w;
    int        r;
    w.op  = OP_READ;
    w.sc  = 7'($urandom_range(0, 127));
    w.off = 2'($urandom_range(0, 3));
    w.wd  = 8'($urandom_range(0, 255));
    w.pit = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      w.op = ($urandom_range(0, 1) != 0) ? OP_BREAK : OP_MAKE;
    end else if (r >= 60 && r < 90) begin
      w.op              = OP_WRITE;
      w.off             = PORT_B;
      w.wd[PB_IRQ_CLR]  = ~pb_m[PB_IRQ_CLR];
    end else if (r >= 90) begin
      w.op = OP_WRITE;
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input ppi_word_t w, input int gap, input logic chk,
                           input ppi_res_t typed);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode      <= w.op;
    in_scancode    <= w.sc;
    in_port_offset <= w.off;
    in_write_data  <= w.wd;
    in_pit_ch2_out <= w.pit;
    cur_chk        <= chk;
    cur_typed      <= typed;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (ppi_res_q.size() != 0);
  endtask

  // write, or read back and compare; only the low nibble is kept
  task automatic cfg_access(input logic wr, input logic idx, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      if (idx == REG_DIP_HIGH) dip_hi_m = data[3:0];
      else dip_lo_m = data[3:0];
    end else if (cfg_prdata !== {{(CFG_DW-4){1'b0}}, data[3:0]}) begin
      $error("prdata expected %0h actual %0h", data[3:0], cfg_prdata);
      n_cfg_fail++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      low_left  = HOLD_CYCLES;
    end
    if (low_left > 0) begin
      low_left--;
      out_ready <= 1'b0;
    end else if (no_stall) begin
      out_ready <= 1'b1;
    end else begin
      rdy_roll = $urandom_range(0, 99);
      if (rdy_roll < 75) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        low_left = (rdy_roll < 96) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk) begin : mon_blk
    ppi_word_t w;
    ppi_res_t  e;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        w = '{op_t'(in_opcode), in_scancode, in_port_offset, in_write_data, in_pit_ch2_out};
        e = kbd_ppi_step(w);
        ppi_res_q.push_back(cur_chk ? cur_typed : e);
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (ppi_res_q.size() == 0) begin
          $error("result word with nothing expected");
          n_fail++;
        end else begin
          e = ppi_res_q.pop_front();
          if (out_read_data !== e.rd) begin
            $error("read_data expected %0h actual %0h", e.rd, out_read_data);
            n_fail++;
          end
          if (out_irq_line !== e.irq) begin
            $error("irq_line expected %0b actual %0b", e.irq, out_irq_line);
            n_fail++;
          end
          if (out_speaker_gate !== e.gate) begin
            $error("speaker_gate expected %0b actual %0b", e.gate, out_speaker_gate);
            n_fail++;
          end
          if (out_speaker_enable !== e.en) begin
            $error("speaker_enable expected %0b actual %0b", e.en, out_speaker_enable);
            n_fail++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    ppi_word_t         w;
    logic [CFG_DW-1:0] lo;
    logic [CFG_DW-1:0] hi;
    logic              burst;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      for (int k = 0; k < dir_tab[i].rep; k++) begin
        w    = dir_tab[i].w;
        w.sc = 7'(w.sc + k);
        send_word(w, pick_gap(), dir_tab[i].chk, dir_tab[i].res);
      end
    end

    for (int p = 0; p < 4; p++) begin
      pause_until_drained();
      repeat (4) @(negedge clk);
      lo = $urandom;
      hi = $urandom;
      if (p != 3) begin
        lo[3:0] = (p == 1) ? 4'h0 : 4'hF;
        hi[3:0] = (p == 2) ? 4'h0 : 4'hF;
      end
      cfg_access(1'b1, REG_DIP_LOW, lo);
      cfg_access(1'b1, REG_DIP_HIGH, hi);
      cfg_access(1'b0, REG_DIP_LOW, lo);
      cfg_access(1'b0, REG_DIP_HIGH, hi);

      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (k == 50) begin
          case (p)
            1: hold_req <= 1'b1;
            2: pause_until_drained();
            3: no_stall <= 1'b1;
            default: ;
          endcase
        end
        if (k == 90) no_stall <= 1'b0;
        // back-to-back words while the receiver is held off or never stalls
        burst = (k >= 50 && k < 90 && (p == 1 || p == 3));
        if (!burst && $urandom_range(0, 99) == 0) begin
          for (int j = 0; j < 18; j++) begin
            w    = gen_word();
            w.op = ($urandom_range(0, 1) != 0) ? OP_BREAK : OP_MAKE;
            send_word(w, 0, 1'b0, '0);
          end
        end
        send_word(gen_word(), burst ? 0 : pick_gap(), 1'b0, '0);
      end
    end

    pause_until_drained();
    repeat (8) @(negedge clk);
    if (n_fail == 0 && n_cfg_fail == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: xt_keyboard_ppi_port.f
sv/xkp_pkg.sv
sv/xkp_fifo.sv
sv/xt_keyboard_ppi_port.sv
bench/tb_top.sv
